>>> hdl/pic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_pkg
// Shared constants, types and saturating arithmetic for the particle push.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int FRACTION_BITS = 40;
  localparam int GRID_COLUMNS  = 256;
  // Rows wrap by masking, so the row count is kept a power of two.
  localparam int GRID_ROWS     = 128;

  localparam int ADDR_W   = 15;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int COL_W    = $clog2(GRID_COLUMNS);
  localparam int ROW_W    = $clog2(GRID_ROWS);
  localparam int WGT_W    = FRACTION_BITS + 1;
  localparam int FIFO_D   = 8;
  localparam int FIFO_AW  = $clog2(FIFO_D);
  localparam int CREDIT_W = $clog2(FIFO_D + 1);
  localparam int CTX_N    = 19;

  localparam logic [62:0] INV_CELL_RST  = 63'd1099511627776;
  localparam logic [63:0] KICK_RST      = 64'd0;
  localparam logic [62:0] TIME_STEP_RST = 63'd10995116;
  localparam logic [62:0] LENGTH_RST    = 63'd0;

  localparam logic signed [63:0] Q_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] Q_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [2:0] {
    REG_INV_CELL  = 3'd0,
    REG_KICK      = 3'd1,
    REG_TIME_STEP = 3'd2,
    REG_LENGTH_X  = 3'd3,
    REG_LENGTH_Y  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_KEPT = 2'd0,
    ST_LOST = 2'd1,
    ST_WRAP = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic [1:0]         status;
    logic               last;
  } out_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? Q_MIN : Q_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    logic signed [63:0] r;
    r = (a == Q_MIN) ? Q_MAX : -a;
    return r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [63:0] c);
    logic [COL_W-1:0] r;
    if (c < 0) begin
      r = '0;
    end else if (c > 64'(GRID_COLUMNS - 1)) begin
      r = COL_W'(GRID_COLUMNS - 1);
    end else begin
      r = c[COL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] col,
                                                input logic [ROW_W-1:0] row);
    logic [31:0] t;
    t = 32'(col) * 32'(GRID_ROWS) + 32'(row);
    return t[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/pic_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pic_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hdl/pic_mulq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_mulq
// Three-stage fixed-point multiplier: floor of the exact product, saturated.
// ----------------------------------------------------------------------------
module pic_mulq (
  input  wire                clk,
  input  wire signed  [63:0] a_i,
  input  wire signed  [63:0] b_i,
  output logic signed [63:0] p_o
);
  import pic_pkg::*;

  logic        neg1_r, neg2_r;
  logic [63:0] ua_r, ub_r, ua_nxt, ub_nxt;
  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  logic [127:0] prod, sgnd;
  logic signed [127:0] shf;
  logic signed [63:0] p_nxt;

  always_comb begin
    ua_nxt = a_i[63] ? (64'd0 - a_i) : a_i;
    ub_nxt = b_i[63] ? (64'd0 - b_i) : b_i;
  end

  always_comb begin
    prod = {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {hh_r, 64'd0};
    sgnd = neg2_r ? (128'd0 - prod) : prod;
    shf  = $signed(sgnd) >>> FRACTION_BITS;
    // In range when the bits above the result all copy its sign.
    if ((shf[127:63] == '0) || (shf[127:63] == '1)) begin
      p_nxt = shf[63:0];
    end else begin
      p_nxt = shf[127] ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r <= a_i[63] ^ b_i[63];
    ua_r   <= ua_nxt;
    ub_r   <= ub_nxt;
    neg2_r <= neg1_r;
    ll_r   <= ua_r[31:0]  * ub_r[31:0];
    lh_r   <= ua_r[31:0]  * ub_r[63:32];
    hl_r   <= ua_r[63:32] * ub_r[31:0];
    hh_r   <= ua_r[63:32] * ub_r[63:32];
    p_o    <= p_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/pic_ofifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_ofifo
// Result queue that decouples the fixed-latency pipeline from the consumer.
// ----------------------------------------------------------------------------
module pic_ofifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  pic_pkg::out_t   push_data,
  input  wire             pop,
  output logic            not_empty,
  output pic_pkg::out_t   head
);
  import pic_pkg::*;

  out_t               ent_r [FIFO_D];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CREDIT_W-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign head      = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CREDIT_W'(push) - CREDIT_W'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/pic_particle_push_bilinear.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_particle_push_bilinear
// Bilinear field interpolation and particle push over two field grid RAMs.
// ----------------------------------------------------------------------------
// A load item writes one entry of both field grids. A push item blocks further
// input for a gap, so that its four grid corners, read one per cycle through
// the single read port of each field RAM, do not collide with the next item;
// loads are taken one per cycle while the input does not stall. Results are
// queued from the last context stage; up to eight results queue at the output,
// and the input stalls when eight pushes are outstanding. Loads are written at
// the same pipeline point where pushes read, so grid updates keep item order.
module pic_particle_push_bilinear (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [63:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_action,
  input  wire  [14:0]        in_grid_index,
  input  wire signed [63:0]  in_field_x,
  input  wire signed [63:0]  in_field_y,
  input  wire signed [63:0]  in_position_x,
  input  wire signed [63:0]  in_position_y,
  input  wire signed [63:0]  in_velocity_x,
  input  wire signed [63:0]  in_velocity_y,
  input  wire                in_last_particle,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [63:0] out_new_position_x,
  output logic signed [63:0] out_new_position_y,
  output logic signed [63:0] out_new_velocity_x,
  output logic signed [63:0] out_new_velocity_y,
  output logic [1:0]         out_status,
  output logic               out_last_out
);
  import pic_pkg::*;

  typedef struct packed {
    logic               valid;
    logic               push;
    logic               last;
    logic [ADDR_W-1:0]  gidx;
    logic signed [63:0] pxd;
    logic signed [63:0] pyd;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
  } tok_t;

  typedef struct packed {
    tok_t              tok;
    logic [COL_W-1:0]  c0;
    logic [COL_W-1:0]  c1;
    logic [ROW_W-1:0]  r0;
    logic [ROW_W-1:0]  r1;
    logic [WGT_W-1:0]  wx0;
    logic [WGT_W-1:0]  wx1;
    logic [WGT_W-1:0]  wy0;
    logic [WGT_W-1:0]  wy1;
  } ctx_t;

  // Configuration.
  logic [62:0]        inv_r, ts_r, lx_r, ly_r;
  logic signed [63:0] kick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= INV_CELL_RST;
      kick_r <= KICK_RST;
      ts_r   <= TIME_STEP_RST;
      lx_r   <= LENGTH_RST;
      ly_r   <= LENGTH_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INV_CELL:  inv_r  <= cfg_data[62:0];
        REG_KICK:      kick_r <= cfg_data;
        REG_TIME_STEP: ts_r   <= cfg_data[62:0];
        REG_LENGTH_X:  lx_r   <= cfg_data[62:0];
        REG_LENGTH_Y:  ly_r   <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  // Input admission: a push blocks further input while its gap counter runs
  // down, and pushes are limited to the result queue depth.
  logic [1:0]          gap_r;
  logic [CREDIT_W-1:0] credit_r;
  logic                in_xfer, out_xfer, push_xfer;

  assign in_stall  = !rst_n || (gap_r != 2'd0) || (credit_r == CREDIT_W'(FIFO_D));
  assign in_xfer   = in_valid && !in_stall;
  assign push_xfer = in_xfer && in_action;
  assign out_xfer  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r    <= 2'd0;
      credit_r <= '0;
    end else begin
      if (push_xfer) begin
        gap_r <= 2'd3;
      end else if (gap_r != 2'd0) begin
        gap_r <= gap_r - 2'd1;
      end
      credit_r <= credit_r + CREDIT_W'(push_xfer) - CREDIT_W'(out_xfer);
    end
  end

  // Front pipeline: position to cell index.
  tok_t s_r [4];
  tok_t in_tok;

  always_comb begin
    in_tok.valid = in_xfer;
    in_tok.push  = in_action;
    in_tok.last  = in_last_particle;
    in_tok.gidx  = in_grid_index;
    in_tok.pxd   = in_action ? in_position_x : in_field_x;
    in_tok.pyd   = in_action ? in_position_y : in_field_y;
    in_tok.vx    = in_velocity_x;
    in_tok.vy    = in_velocity_y;
  end

  logic signed [63:0] jx, jy;

  pic_mulq u_mul_jx (.clk(clk), .a_i(s_r[0].pxd), .b_i({1'b0, inv_r}), .p_o(jx));
  pic_mulq u_mul_jy (.clk(clk), .a_i(s_r[0].pyd), .b_i({1'b0, inv_r}), .p_o(jy));

  ctx_t               cell_nxt;
  logic signed [63:0] ix, iy;
  logic [WGT_W-1:0]   one_q;

  always_comb begin
    one_q        = WGT_W'(1) << FRACTION_BITS;
    ix           = jx >>> FRACTION_BITS;
    iy           = jy >>> FRACTION_BITS;
    cell_nxt.tok = s_r[3];
    cell_nxt.c0  = clamp_col(ix);
    cell_nxt.c1  = clamp_col(ix + 64'sd1);
    cell_nxt.r0  = iy[ROW_W-1:0];
    cell_nxt.r1  = iy[ROW_W-1:0] + 1'b1;
    cell_nxt.wx1 = {1'b0, jx[FRACTION_BITS-1:0]};
    cell_nxt.wx0 = one_q - {1'b0, jx[FRACTION_BITS-1:0]};
    cell_nxt.wy1 = {1'b0, jy[FRACTION_BITS-1:0]};
    cell_nxt.wy0 = one_q - {1'b0, jy[FRACTION_BITS-1:0]};
  end

  ctx_t ctx_r [CTX_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        s_r[i].valid <= 1'b0;
      end
      for (int i = 0; i < CTX_N; i++) begin
        ctx_r[i].tok.valid <= 1'b0;
      end
    end else begin
      s_r[0] <= in_tok;
      for (int i = 1; i < 4; i++) begin
        s_r[i] <= s_r[i-1];
      end
      ctx_r[0] <= cell_nxt;
      for (int i = 1; i < CTX_N; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
    end
  end

  // Corner beats: the push sitting in context stage k reads corner k.
  logic [ADDR_W-1:0] rd_addr;
  logic [WGT_W-1:0]  wa, wb;

  always_comb begin
    rd_addr = '0;
    wa      = '0;
    wb      = '0;
    for (int k = 0; k < 4; k++) begin
      if (ctx_r[k].tok.valid && ctx_r[k].tok.push) begin
        rd_addr = addr_of(((k & 1) != 0) ? ctx_r[k].c1 : ctx_r[k].c0,
                          ((k & 2) != 0) ? ctx_r[k].r1 : ctx_r[k].r0);
        wa      = ((k & 1) != 0) ? ctx_r[k].wx1 : ctx_r[k].wx0;
        wb      = ((k & 2) != 0) ? ctx_r[k].wy1 : ctx_r[k].wy0;
      end
    end
  end

  logic        ld_we;
  logic [63:0] rdx, rdy;
  logic signed [63:0] rdx1_r, rdy1_r, rdx2_r, rdy2_r;

  assign ld_we = ctx_r[0].tok.valid && !ctx_r[0].tok.push;

  pic_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_ex (
    .clk(clk), .wr_en(ld_we), .wr_addr(ctx_r[0].tok.gidx), .wr_data(ctx_r[0].tok.pxd),
    .rd_addr(rd_addr), .rd_data(rdx)
  );
  pic_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_ey (
    .clk(clk), .wr_en(ld_we), .wr_addr(ctx_r[0].tok.gidx), .wr_data(ctx_r[0].tok.pyd),
    .rd_addr(rd_addr), .rd_data(rdy)
  );

  // Align the read data with the corner weight.
  always_ff @(posedge clk) begin
    rdx1_r <= rdx;
    rdy1_r <= rdy;
    rdx2_r <= rdx1_r;
    rdy2_r <= rdy1_r;
  end

  logic signed [63:0] wgt, fpx, fpy;

  pic_mulq u_mul_w (.clk(clk), .a_i({{(64-WGT_W){1'b0}}, wa}),
                    .b_i({{(64-WGT_W){1'b0}}, wb}), .p_o(wgt));
  pic_mulq u_mul_fx (.clk(clk), .a_i(wgt), .b_i(rdx2_r), .p_o(fpx));
  pic_mulq u_mul_fy (.clk(clk), .a_i(wgt), .b_i(rdy2_r), .p_o(fpy));

  // Interpolation sums, corner 0 first.
  logic signed [63:0] accx_r, accy_r;

  always_ff @(posedge clk) begin
    if (ctx_r[6].tok.valid && ctx_r[6].tok.push) begin
      accx_r <= fpx;
      accy_r <= fpy;
    end else if ((ctx_r[7].tok.valid && ctx_r[7].tok.push) ||
                 (ctx_r[8].tok.valid && ctx_r[8].tok.push) ||
                 (ctx_r[9].tok.valid && ctx_r[9].tok.push)) begin
      accx_r <= sat_add(accx_r, fpx);
      accy_r <= sat_add(accy_r, fpy);
    end
  end

  // Kick and move.
  logic signed [63:0] kpx, kpy, mpx, mpy;
  logic signed [63:0] vx1_r [5];
  logic signed [63:0] vy1_r [5];
  logic signed [63:0] px2_r, py2_r;

  pic_mulq u_mul_kx (.clk(clk), .a_i(kick_r), .b_i(accx_r), .p_o(kpx));
  pic_mulq u_mul_ky (.clk(clk), .a_i(kick_r), .b_i(accy_r), .p_o(kpy));
  pic_mulq u_mul_mx (.clk(clk), .a_i(vx1_r[0]), .b_i({1'b0, ts_r}), .p_o(mpx));
  pic_mulq u_mul_my (.clk(clk), .a_i(vy1_r[0]), .b_i({1'b0, ts_r}), .p_o(mpy));

  always_ff @(posedge clk) begin
    vx1_r[0] <= sat_add(ctx_r[13].tok.vx, kpx);
    vy1_r[0] <= sat_add(ctx_r[13].tok.vy, kpy);
    for (int i = 1; i < 5; i++) begin
      vx1_r[i] <= vx1_r[i-1];
      vy1_r[i] <= vy1_r[i-1];
    end
    px2_r <= sat_add(ctx_r[17].tok.pxd, mpx);
    py2_r <= sat_add(ctx_r[17].tok.pyd, mpy);
  end

  // Boundaries: reflect at the left wall, wrap y, flag losses.
  out_t               res;
  logic signed [63:0] ly, lx;

  always_comb begin
    ly         = {1'b0, ly_r};
    lx         = {1'b0, lx_r};
    res.px     = px2_r;
    res.py     = py2_r;
    res.vx     = vx1_r[4];
    res.vy     = vy1_r[4];
    res.status = ST_KEPT;
    res.last   = ctx_r[18].tok.last;
    if (px2_r < 0) begin
      res.px = sat_neg(px2_r);
      res.vx = sat_neg(vx1_r[4]);
    end
    if (py2_r > ly) begin
      res.py = py2_r - ly;
      if (res.py > ly) begin
        res.status = ST_WRAP;
      end
    end else if (py2_r < 0) begin
      res.py = py2_r + ly;
      if (res.py < 0) begin
        res.status = ST_WRAP;
      end
    end
    if (res.px > lx) begin
      res.status = ST_LOST;
    end
  end

  out_t head;

  pic_ofifo u_ofifo (
    .clk(clk), .rst_n(rst_n),
    .push(ctx_r[18].tok.valid && ctx_r[18].tok.push), .push_data(res),
    .pop(out_xfer), .not_empty(out_valid), .head(head)
  );

  assign out_new_position_x = head.px;
  assign out_new_position_y = head.py;
  assign out_new_velocity_x = head.vx;
  assign out_new_velocity_y = head.vy;
  assign out_status         = head.status;
  assign out_last_out       = head.last;

endmodule
`default_nettype wire
